/* sv/strs_pkg.sv */
// shared types and constants for the segment tree range sum block
`timescale 1ns / 1ps

package strs_pkg;

	// default number of leaves in the tree
	localparam int unsigned LEAVES_DEF = 1024;

	// field widths
	localparam int unsigned POS_W = 10;
	localparam int unsigned VAL_W = 32;

	// operation codes carried in the mode field
	localparam logic MODE_UPDATE = 1'b0;
	localparam logic MODE_QUERY  = 1'b1;

	// one input transaction
	typedef struct packed {
		logic                    mode;
		logic [POS_W-1:0]        left;
		logic [POS_W-1:0]        right;
		logic signed [VAL_W-1:0] value;
	} req_t;

	// one result transaction
	typedef struct packed {
		logic                    was_query;
		logic signed [VAL_W-1:0] range_sum;
	} rsp_t;

endpackage

/* sv/segment_tree_range_sum.sv */
// segment tree with point update and wrapping range sum, node sums in one memory
`timescale 1ns / 1ps

// Usage
// A transaction is taken on req at a rising edge where start is high and busy
// is low. Every transaction gives exactly one result on rsp, shown for one
// cycle with done high; the receiver cannot hold it off.
// Node sums live in a memory of 2*LEAVES words with one write port and two
// registered read ports. An update writes the leaf, then walks up one level
// per cycle, adding the sibling read in the previous cycle and writing the
// parent, up to and including the root, after which done rises.
// A query walks both range ends up one level per cycle, reading up to two
// nodes per level on the two read ports.
// An update past the end, an empty range or a range starting past the end
// gives its result in the cycle after it is taken, and start may be taken
// again in the cycle in which done is high.
// After reset, busy stays high for a clearing pass that writes zero to every
// node; no transaction is taken before it ends.
module segment_tree_range_sum #(
	parameter int unsigned LEAVES = strs_pkg::LEAVES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  strs_pkg::req_t req,
	output logic           done,
	output strs_pkg::rsp_t rsp
);

	localparam int unsigned AW = $clog2(2 * LEAVES);
	localparam int unsigned IW = AW + 1;
	localparam int unsigned VW = strs_pkg::VAL_W;
	localparam logic [IW-1:0] LEAVES_W = IW'(LEAVES);
	localparam logic [AW-1:0] LAST_ADDR = AW'(2 * LEAVES - 1);
	localparam logic [AW-1:0] ROOT_ADDR = AW'(1);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPDATE,
		ST_QUERY
	} state_t;

	state_t          state_q;
	logic [AW-1:0]   clr_q;
	logic [AW-1:0]   k_q;
	logic [VW-1:0]   cur_q;
	logic            first_q;
	logic [IW-1:0]   l_q;
	logic [IW-1:0]   r_q;
	logic [VW-1:0]   acc_q;
	logic            use_a_q;
	logic            use_b_q;
	logic            done_q;
	strs_pkg::rsp_t  rsp_q;

	// node memory
	logic [VW-1:0]   node_mem [2 * LEAVES];
	logic [VW-1:0]   rd_a_q;
	logic [VW-1:0]   rd_b_q;

	logic            we;
	logic [AW-1:0]   waddr;
	logic [VW-1:0]   wdata;
	logic [AW-1:0]   raddr_a;
	logic [AW-1:0]   raddr_b;

	logic            accept;
	logic [IW-1:0]   lo;
	logic [IW-1:0]   hi;
	logic [IW-1:0]   hi_clamp;
	logic [IW-1:0]   r_dec;
	logic [VW-1:0]   upd_sum;
	logic [VW-1:0]   qry_sum;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign rsp    = rsp_q;

	// query range bounds, right end clamped to the last leaf
	assign lo       = IW'(req.left);
	assign hi       = IW'(req.right);
	assign hi_clamp = (hi > LEAVES_W - IW'(1)) ? LEAVES_W - IW'(1) : hi;
	assign r_dec    = r_q - IW'(1);

	// new node value on the upward walk: the leaf itself, then value plus sibling
	assign upd_sum = first_q ? cur_q : cur_q + rd_a_q;

	// running query sum with the reads issued in the previous cycle
	assign qry_sum = acc_q + (use_a_q ? rd_a_q : '0) + (use_b_q ? rd_b_q : '0);

	// memory port control
	always_comb begin
		we      = 1'b0;
		waddr   = clr_q;
		wdata   = '0;
		raddr_a = k_q ^ ROOT_ADDR;
		raddr_b = r_dec[AW-1:0];
		unique case (state_q)
			ST_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = '0;
			end
			ST_UPDATE: begin
				we    = 1'b1;
				waddr = k_q;
				wdata = upd_sum;
			end
			ST_QUERY: begin
				raddr_a = l_q[AW-1:0];
				raddr_b = r_dec[AW-1:0];
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (we) begin
			node_mem[waddr] <= wdata;
		end
		rd_a_q <= node_mem[raddr_a];
		rd_b_q <= node_mem[raddr_b];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			k_q     <= '0;
			cur_q   <= '0;
			l_q     <= '0;
			r_q     <= '0;
			acc_q   <= '0;
			rsp_q   <= '0;
			done_q  <= 1'b0;
			first_q <= 1'b0;
			use_a_q <= 1'b0;
			use_b_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				// zero every node once after reset
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end
				end

				// take a transaction, finish trivial ones at once
				ST_IDLE: begin
					if (accept) begin
						if (req.mode == strs_pkg::MODE_UPDATE) begin
							if (lo < LEAVES_W) begin
								k_q     <= AW'(lo + LEAVES_W);
								cur_q   <= req.value;
								first_q <= 1'b1;
								state_q <= ST_UPDATE;
							end else begin
								done_q <= 1'b1;
								rsp_q  <= '{was_query: 1'b0, range_sum: '0};
							end
						end else begin
							if (lo > hi_clamp) begin
								done_q <= 1'b1;
								rsp_q  <= '{was_query: 1'b1, range_sum: '0};
							end else begin
								l_q     <= lo + LEAVES_W;
								r_q     <= hi_clamp + LEAVES_W + IW'(1);
								acc_q   <= '0;
								use_a_q <= 1'b0;
								use_b_q <= 1'b0;
								state_q <= ST_QUERY;
							end
						end
					end
				end

				// write this node, fetch its sibling, step to the parent
				ST_UPDATE: begin
					cur_q   <= upd_sum;
					first_q <= 1'b0;
					if (k_q == ROOT_ADDR) begin
						done_q  <= 1'b1;
						rsp_q   <= '{was_query: 1'b0, range_sum: '0};
						state_q <= ST_IDLE;
					end else begin
						k_q <= k_q >> 1;
					end
				end

				// fold in last level's reads, issue this level's, step both ends up
				ST_QUERY: begin
					acc_q <= qry_sum;
					if (l_q < r_q) begin
						use_a_q <= l_q[0];
						use_b_q <= r_q[0];
						l_q     <= (l_q + IW'(l_q[0])) >> 1;
						r_q     <= r_q >> 1;
					end else begin
						done_q  <= 1'b1;
						rsp_q   <= '{was_query: 1'b1, range_sum: qry_sum};
						use_a_q <= 1'b0;
						use_b_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// a result only appears once the block is free again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// queries never modify the node store
	a_query_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_QUERY) |-> !we)
		else $error("node write during query");

	// the update walk never reaches the unused node zero
	a_walk_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE) |-> (k_q != '0))
		else $error("update walk at node zero");

	// an accepted update in range starts the walk at the next edge
	a_update_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req.mode == strs_pkg::MODE_UPDATE) && (lo < LEAVES_W))
		|=> (state_q == ST_UPDATE) && first_q)
		else $error("update walk not started");

endmodule

/* tb/sv/tb_segment_tree_range_sum.sv */
// self-checking testbench for the segment tree range sum block
`timescale 1ns / 1ps

module tb_segment_tree_range_sum;

	localparam int unsigned N_LEAVES    = strs_pkg::LEAVES_DEF;
	localparam int unsigned POS_W       = strs_pkg::POS_W;
	localparam int unsigned VAL_W       = strs_pkg::VAL_W;
	localparam int unsigned REQ_W       = $bits(strs_pkg::req_t);
	localparam int unsigned RANDOM_OPS  = 1030;
	localparam int unsigned DRAIN_WAIT  = 24;
	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(N_LEAVES - 1);

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	strs_pkg::req_t req;
	logic done;
	strs_pkg::rsp_t rsp;

	// element values as the block should hold them
	logic [VAL_W-1:0]  elem_vals [N_LEAVES];
	strs_pkg::rsp_t    pending_results [$];
	int unsigned       fail_count = 0;
	int unsigned       cycle_count = 0;

	segment_tree_range_sum #(
		.LEAVES(N_LEAVES)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.done  (done),
		.rsp   (rsp)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("segment_tree_range_sum regression: fail");
			$finish;
		end
	end

	// apply one transaction to the element copy and return the expected result
	function automatic strs_pkg::rsp_t model_transaction(input strs_pkg::req_t item);
		strs_pkg::rsp_t   res;
		int unsigned      lo;
		int unsigned      hi;
		logic [VAL_W-1:0] acc;
		res = '0;
		acc = '0;
		lo  = 32'(item.left);
		hi  = 32'(item.right);
		if (item.mode == strs_pkg::MODE_UPDATE) begin
			// writes past the end are dropped but still acknowledged
			if (lo < N_LEAVES)
				elem_vals[item.left] = item.value;
		end else begin
			res.was_query = 1'b1;
			// clamp the end, empty ranges sum to zero
			if (hi > N_LEAVES - 1)
				hi = N_LEAVES - 1;
			if (lo <= hi) begin
				for (int unsigned i = lo; i <= hi; i++)
					acc = acc + elem_vals[POS_W'(i)];
			end
			res.range_sum = acc;
		end
		return res;
	endfunction

	// present one transaction and hold it until the block takes it
	task automatic issue_op(input strs_pkg::req_t item);
		req   <= item;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		pending_results.push_back(model_transaction(item));
	endtask

	// drop start for the requested gap, with junk on the request bus
	task automatic idle_cycles(input int unsigned n);
		if (n > 0) begin
			start <= 1'b0;
			for (int unsigned i = 0; i < n; i++) begin
				req <= REQ_W'({$urandom(), $urandom()});
				@(posedge clk);
			end
		end
	endtask

	// mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 40)
			return 0;
		else if (roll < 85)
			return $urandom_range(1, 3);
		else if (roll < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(30, 60);
	endfunction

	function automatic strs_pkg::req_t make_update(input logic [POS_W-1:0] pos,
			input logic [VAL_W-1:0] val);
		strs_pkg::req_t item;
		item.mode  = strs_pkg::MODE_UPDATE;
		item.left  = pos;
		item.right = POS_W'($urandom());
		item.value = val;
		return item;
	endfunction

	function automatic strs_pkg::req_t make_query(input logic [POS_W-1:0] lo,
			input logic [POS_W-1:0] hi);
		strs_pkg::req_t item;
		item.mode  = strs_pkg::MODE_QUERY;
		item.left  = lo;
		item.right = hi;
		item.value = $urandom();
		return item;
	endfunction

	// position biased toward the edges and a small cluster
	function automatic logic [POS_W-1:0] rand_pos();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return POS_W'($urandom_range(0, N_LEAVES - 1));
		else if (roll < 70)
			return POS_W'($urandom_range(0, 15));
		else if (roll < 80)
			return POS_W'($urandom_range(N_LEAVES - 16, N_LEAVES - 1));
		else if (roll < 90)
			return ($urandom_range(0, 1) != 0) ? POS_LAST : '0;
		else
			return POS_W'($urandom_range(N_LEAVES / 2 - 8, N_LEAVES / 2 + 8));
	endfunction

	// full-range, small or extreme values
	function automatic logic [VAL_W-1:0] rand_value();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return $urandom();
		else if (roll < 80)
			return VAL_W'($signed($urandom_range(0, 200)) - 100);
		else if (roll < 90)
			return ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
		else
			return ($urandom_range(0, 1) != 0) ? 32'hffff_ffff : 32'h0000_0000;
	endfunction

	function automatic strs_pkg::req_t rand_query();
		int unsigned      roll;
		logic [POS_W-1:0] lo;
		int unsigned      hi;
		roll = $urandom_range(0, 99);
		lo   = rand_pos();
		if (roll < 15)
			return make_query(POS_W'($urandom()), POS_W'($urandom()));
		else if (roll < 25)
			return make_query(lo, lo);
		else if (roll < 35)
			return make_query('0, POS_LAST);
		else if (roll < 45) begin
			// empty range, left past right
			if (lo == '0)
				lo = POS_W'(1);
			return make_query(lo, POS_W'($urandom_range(0, lo - 1)));
		end else begin
			if (roll < 75)
				hi = lo + $urandom_range(0, 16);
			else
				hi = lo + $urandom_range(0, N_LEAVES - 1);
			if (hi > N_LEAVES - 1)
				hi = N_LEAVES - 1;
			return make_query(lo, POS_W'(hi));
		end
	endfunction

	// compare each result transaction with the oldest prediction
	always @(posedge clk) begin : result_check
		strs_pkg::rsp_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result was_query=%0b range_sum=%h",
					$time, rsp.was_query, rsp.range_sum);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (rsp.was_query !== want.was_query) begin
					$display("%0t: was_query expected %0b actual %0b",
						$time, want.was_query, rsp.was_query);
					fail_count++;
				end
				if (rsp.range_sum !== want.range_sum) begin
					$display("%0t: range_sum expected %h (%0d) actual %h (%0d)",
						$time, want.range_sum, want.range_sum,
						rsp.range_sum, rsp.range_sum);
					fail_count++;
				end
			end
		end
	end

	// queries on the freshly cleared tree
	task automatic test_cleared_tree();
		issue_op(make_query('0, POS_LAST));
		issue_op(make_query('0, '0));
		issue_op(make_query(POS_LAST, POS_LAST));
	endtask

	// extreme positions and values
	task automatic test_field_extremes();
		issue_op(make_update('0, 32'h7fff_ffff));
		issue_op(make_update(POS_LAST, 32'h8000_0000));
		issue_op(make_update(POS_W'(N_LEAVES / 2), 32'hffff_ffff));
		issue_op(make_query('0, '0));
		issue_op(make_query(POS_LAST, POS_LAST));
		issue_op(make_query('0, POS_LAST));
		idle_cycles(3);
		issue_op(make_query(POS_W'(N_LEAVES / 2), POS_LAST));
	endtask

	// sums that wrap past the signed limits
	task automatic test_sum_wrap();
		issue_op(make_update(POS_W'(1), 32'h7fff_ffff));
		issue_op(make_query('0, POS_W'(1)));
		issue_op(make_update(POS_W'(N_LEAVES - 2), 32'h8000_0000));
		issue_op(make_query(POS_W'(N_LEAVES - 2), POS_LAST));
		issue_op(make_query('0, POS_LAST));
	endtask

	// empty ranges with left past right
	task automatic test_empty_ranges();
		issue_op(make_query(POS_W'(5), POS_W'(4)));
		issue_op(make_query(POS_LAST, '0));
		idle_cycles(1);
		issue_op(make_query(POS_W'(1), '0));
	endtask

	// value on a query and right on an update have no effect
	task automatic test_ignored_fields();
		strs_pkg::req_t item;
		item = make_update(POS_W'(7), 32'h0000_1234);
		item.right = POS_LAST;
		issue_op(item);
		item = make_query(POS_W'(7), POS_W'(7));
		item.value = 32'hdead_beef;
		issue_op(item);
		issue_op(make_query('0, POS_W'(7)));
	endtask

	// mixed updates and queries, bursts alternating with random gaps
	task automatic test_random_traffic();
		strs_pkg::req_t item;
		bit             burst;
		burst = 1'b0;
		for (int unsigned n = 0; n < RANDOM_OPS; n++) begin
			if (n % 60 == 0)
				burst = ($urandom_range(0, 2) == 0);
			if ($urandom_range(0, 99) < 45)
				item = make_update(rand_pos(), rand_value());
			else
				item = rand_query();
			issue_op(item);
			if (!burst)
				idle_cycles(pick_gap());
		end
	endtask

	// stimulus sequence
	initial begin
		arst_n = 1'b0;
		start  = 1'b0;
		req    = '0;
		for (int unsigned i = 0; i < N_LEAVES; i++)
			elem_vals[i] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_cleared_tree();
		test_field_extremes();
		test_sum_wrap();
		test_empty_ranges();
		test_ignored_fields();
		test_random_traffic();
		start <= 1'b0;

		// let the last results come back
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (fail_count == 0)
			$display("segment_tree_range_sum regression: pass");
		else
			$display("segment_tree_range_sum regression: fail");
		$finish;
	end

endmodule

/* segment_tree_range_sum.f */
sv/strs_pkg.sv
sv/segment_tree_range_sum.sv
tb/sv/tb_segment_tree_range_sum.sv
